/* rtl/sso_pkg.sv */
package sso_pkg;

    // Scan limits
    localparam int MAX_SAMPLES = 4096;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

    // Field widths
    localparam int RANGE_W = 16;
    localparam int HITS_W  = 13;
    localparam int HALF_W  = 22;
    localparam int START_W = 24;
    localparam int STEP_W  = 20;
    localparam int ANGLE_W = 32;

    // Configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Reset values of the registers
    localparam logic [RANGE_W-1:0] NEAR_RESET  = 16'd1200;
    localparam logic [HITS_W-1:0]  STOP_RESET  = 13'd5;
    localparam logic [HALF_W-1:0]  FRONT_RESET = 22'd520000;
    localparam logic [HALF_W-1:0]  SIDE_RESET  = 22'd2620000;
    localparam logic [START_W-1:0] START_RESET = 24'hD01027; // -3141593
    localparam logic [STEP_W-1:0]  STEP_RESET  = 20'd8727;

    // Register indexes
    typedef enum logic [2:0] {
        REG_NEAR  = 3'd0,
        REG_STOP  = 3'd1,
        REG_FRONT = 3'd2,
        REG_SIDE  = 3'd3,
        REG_START = 3'd4,
        REG_STEP  = 3'd5
    } t_reg_idx;

    // Sector codes, also the order of the results
    typedef enum logic [1:0] {
        SEC_FRONT = 2'd0,
        SEC_BACK  = 2'd1,
        SEC_LEFT  = 2'd2,
        SEC_RIGHT = 2'd3
    } t_sector;

    // Register contents handed to the datapath
    typedef struct packed {
        logic [RANGE_W-1:0]        near_range_mm;
        logic [HITS_W-1:0]         stop_count;
        logic [HALF_W-1:0]         front_half_width_urad;
        logic [HALF_W-1:0]         side_limit_urad;
        logic signed [START_W-1:0] angle_start;
        logic [STEP_W-1:0]         angle_step;
    } t_cfg;

endpackage

/* rtl/sso_regs.sv */
module sso_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sso_pkg::ADDR_W-1:0]  paddr,
    input  logic [sso_pkg::DATA_W-1:0]  pwdata,
    output logic [sso_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output sso_pkg::t_cfg               o_cfg
);

    sso_pkg::t_cfg    r_cfg;
    sso_pkg::t_reg_idx idx;
    logic             wr;

    assign pready = 1'b1;
    assign idx    = sso_pkg::t_reg_idx'(paddr[sso_pkg::ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    // Register writes at the access cycle; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_range_mm         <= sso_pkg::NEAR_RESET;
            r_cfg.stop_count            <= sso_pkg::STOP_RESET;
            r_cfg.front_half_width_urad <= sso_pkg::FRONT_RESET;
            r_cfg.side_limit_urad       <= sso_pkg::SIDE_RESET;
            r_cfg.angle_start           <= sso_pkg::START_RESET;
            r_cfg.angle_step            <= sso_pkg::STEP_RESET;
        end else if (wr) begin
            unique case (idx)
                sso_pkg::REG_NEAR:  r_cfg.near_range_mm <= pwdata[sso_pkg::RANGE_W-1:0];
                sso_pkg::REG_STOP:  r_cfg.stop_count <= pwdata[sso_pkg::HITS_W-1:0];
                sso_pkg::REG_FRONT: r_cfg.front_half_width_urad <= pwdata[sso_pkg::HALF_W-1:0];
                sso_pkg::REG_SIDE:  r_cfg.side_limit_urad <= pwdata[sso_pkg::HALF_W-1:0];
                sso_pkg::REG_START: r_cfg.angle_start <= pwdata[sso_pkg::START_W-1:0];
                sso_pkg::REG_STEP:  r_cfg.angle_step <= pwdata[sso_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back; the start angle reads sign extended.
    always_comb begin
        unique case (idx)
            sso_pkg::REG_NEAR:  prdata = sso_pkg::DATA_W'(r_cfg.near_range_mm);
            sso_pkg::REG_STOP:  prdata = sso_pkg::DATA_W'(r_cfg.stop_count);
            sso_pkg::REG_FRONT: prdata = sso_pkg::DATA_W'(r_cfg.front_half_width_urad);
            sso_pkg::REG_SIDE:  prdata = sso_pkg::DATA_W'(r_cfg.side_limit_urad);
            sso_pkg::REG_START: prdata = {{(sso_pkg::DATA_W - sso_pkg::START_W)
                                           {r_cfg.angle_start[sso_pkg::START_W-1]}},
                                          r_cfg.angle_start};
            sso_pkg::REG_STEP:  prdata = sso_pkg::DATA_W'(r_cfg.angle_step);
            default:            prdata = '0;
        endcase
    end

endmodule

/* rtl/scan_sector_obstacle_detector.sv */
// Scan sector obstacle detector. Range samples of a rotating scan enter one word
// per cycle; each sample below the near threshold is counted into the front, left,
// right or back sector by its beam angle, which starts at angle_start and grows by
// angle_step per sample. The sample marked scan_end makes four result words, front,
// back, left, right, each with a stop flag and the smallest range seen; they leave
// from a snapshot register while the next scan already streams in.
// The input takes one sample every cycle; only a scan-end sample is stalled, and
// only while the previous scan's four words are still leaving. Registers should be
// written between scans; the start angle is sampled on the first sample of each scan,
// while the threshold is compared against every sample.
module scan_sector_obstacle_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Sample input
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [sso_pkg::RANGE_W-1:0]   i_range_mm,
    input  logic                          i_scan_end,
    // Result output
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_sector,
    output logic                          o_stop_flag,
    output logic [sso_pkg::RANGE_W-1:0]   o_min_range_mm,
    output logic                          o_last_of_scan,
    // Configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sso_pkg::ADDR_W-1:0]    paddr,
    input  logic [sso_pkg::DATA_W-1:0]    pwdata,
    output logic [sso_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    localparam int CW = sso_pkg::CNT_W;
    localparam int AW = sso_pkg::ANGLE_W;
    localparam int HW = sso_pkg::HITS_W;
    localparam int RW = sso_pkg::RANGE_W;

    sso_pkg::t_cfg cfg;

    logic [CW-1:0]        r_count;
    logic signed [AW-1:0] r_angle;
    logic [HW-1:0]        r_hits [4];
    logic [RW-1:0]        r_min [4];
    logic                 r_snap_stop [4];
    logic [RW-1:0]        r_snap_min [4];
    logic                 r_out_valid;
    logic [1:0]           r_out_idx;

    logic                 n_count_en;
    logic [CW-1:0]        n_count;
    logic signed [AW-1:0] n_angle;
    logic [HW-1:0]        n_hits [4];
    logic [RW-1:0]        n_min [4];

    logic                 first;
    logic                 active;
    logic                 hit;
    logic signed [AW-1:0] ang_cur;
    logic signed [AW:0]   ang_x;
    logic signed [AW:0]   fw_x;
    logic signed [AW:0]   sl_x;
    logic signed [AW:0]   sum;
    sso_pkg::t_sector     sec;
    logic                 in_take;
    logic                 out_take;
    logic                 out_done;

    sso_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Handshakes. A scan-end word waits until the snapshot is free.
    assign out_take = r_out_valid && !i_stall;
    assign out_done = out_take && (r_out_idx == sso_pkg::SEC_RIGHT);
    assign o_stall  = i_scan_end && r_out_valid && !out_done;
    assign in_take  = i_valid && !o_stall;

    // The first sample of a scan starts from the start angle and cleared sectors.
    assign first   = (r_count == '0);
    assign active  = (r_count < CW'(sso_pkg::MAX_SAMPLES));
    assign hit     = active && (i_range_mm < cfg.near_range_mm);
    assign ang_cur = first ? AW'(cfg.angle_start) : r_angle;

    // Sector test in the fixed priority front, left, right, back.
    assign ang_x = (AW + 1)'(ang_cur);
    assign fw_x  = $signed({{(AW + 1 - sso_pkg::HALF_W){1'b0}}, cfg.front_half_width_urad});
    assign sl_x  = $signed({{(AW + 1 - sso_pkg::HALF_W){1'b0}}, cfg.side_limit_urad});

    always_comb begin
        if (ang_x >= -fw_x && ang_x < fw_x) begin
            sec = sso_pkg::SEC_FRONT;
        end else if (ang_x >= fw_x && ang_x < sl_x) begin
            sec = sso_pkg::SEC_LEFT;
        end else if (ang_x >= -sl_x && ang_x < fw_x) begin
            sec = sso_pkg::SEC_RIGHT;
        end else begin
            sec = sso_pkg::SEC_BACK;
        end
    end

    // Next accumulator values for the sample at the input.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_hits[k] = first ? '0 : r_hits[k];
            n_min[k]  = first ? cfg.near_range_mm : r_min[k];
        end
        if (hit) begin
            if (n_hits[sec] != {HW{1'b1}}) begin
                n_hits[sec] = n_hits[sec] + 1'b1;
            end
            if (i_range_mm < n_min[sec]) begin
                n_min[sec] = i_range_mm;
            end
        end
    end

    // Beam angle advance, saturating at the positive limit.
    assign sum = ang_x + $signed({{(AW + 1 - sso_pkg::STEP_W){1'b0}}, cfg.angle_step});

    always_comb begin
        if (!sum[AW] && sum[AW-1]) begin
            n_angle = {1'b0, {(AW - 1){1'b1}}};
        end else begin
            n_angle = sum[AW-1:0];
        end
    end

    assign n_count_en = active && in_take;
    assign n_count    = i_scan_end ? '0 : r_count + 1'b1;

    // Sample counter; a scan end restarts the next scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (in_take && (active || i_scan_end)) begin
            r_count <= n_count;
        end
    end

    // Angle and sector accumulators.
    always_ff @(posedge i_clk) begin
        if (n_count_en) begin
            r_angle <= n_angle;
            for (int k = 0; k < 4; k++) begin
                r_hits[k] <= n_hits[k];
                r_min[k]  <= n_min[k];
            end
        end
    end

    // Snapshot of the four results at scan end.
    always_ff @(posedge i_clk) begin
        if (in_take && i_scan_end) begin
            for (int k = 0; k < 4; k++) begin
                r_snap_stop[k] <= (n_hits[k] >= cfg.stop_count);
                r_snap_min[k]  <= n_min[k];
            end
        end
    end

    // Drain of the snapshot, one word per cycle while the output is not stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_idx   <= '0;
        end else if (in_take && i_scan_end) begin
            r_out_valid <= 1'b1;
            r_out_idx   <= '0;
        end else if (out_take) begin
            r_out_valid <= !out_done;
            r_out_idx   <= r_out_idx + 1'b1;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sector       = r_out_idx;
    assign o_stop_flag    = r_snap_stop[r_out_idx];
    assign o_min_range_mm = r_snap_min[r_out_idx];
    assign o_last_of_scan = (r_out_idx == sso_pkg::SEC_RIGHT);

    // A scan end that was taken starts a drain with the front sector.
    a_drain_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && i_scan_end) |=> (r_out_valid && r_out_idx == sso_pkg::SEC_FRONT))
        else $error("scan end did not start a drain");

    // The input is only held back for a scan end during a drain.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (i_scan_end && r_out_valid))
        else $error("stall without a pending drain");

    // The sample counter never passes the scan limit.
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(sso_pkg::MAX_SAMPLES))
        else $error("sample count beyond limit");

    // The right-sector word closes the drain unless a new scan end is loaded.
    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_done && !(in_take && i_scan_end)) |=> !r_out_valid)
        else $error("drain continued after the last word");

endmodule
